// ----- hw/rtl/tkheap_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkheap_pkg
// shared types and constants of the top-k min-heap selector
// ----------------------------------------------------------------------------
package tkheap_pkg;

    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_KEY_BITS    = 24;
    localparam int DEF_VALUE_BITS  = 32;

    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 2;
    localparam int CFG_BITS    = 7;
    localparam int COUNT_BITS  = 7;

    localparam logic [CFG_BITS-1:0] K_RESET = 7'd64;

    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_DRAIN = 2'd3
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK     = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_EMPTY  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_EMPTY,
        ST_PUSH_CHK,
        ST_UP_RD,
        ST_UP_CMP,
        ST_PUSH_RES,
        ST_POP_RD,
        ST_POP_EMIT,
        ST_DN_RD,
        ST_DN_CMP
    } state_t;

    // control part of one result going to the output stage
    typedef struct packed {
        status_t               status;
        logic [COUNT_BITS-1:0] count_after;
        logic                  last;
    } res_tag_t;

endpackage

// ----- hw/rtl/tkheap_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkheap_mem
// heap entry memory: one write port, two registered read ports
// ----------------------------------------------------------------------------
module tkheap_mem #(
    parameter int MAX_ENTRIES = tkheap_pkg::DEF_MAX_ENTRIES,
    parameter int ENTRY_BITS  = tkheap_pkg::DEF_KEY_BITS + tkheap_pkg::DEF_VALUE_BITS
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
    input  logic [ENTRY_BITS-1:0]          wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr_a,
    input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr_b,
    output logic [ENTRY_BITS-1:0]          rd_data_a,
    output logic [ENTRY_BITS-1:0]          rd_data_b
);
    import tkheap_pkg::*;

    logic [ENTRY_BITS-1:0] mem_array [MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem_array[rd_addr_a];
            rd_data_b <= mem_array[rd_addr_b];
        end
    end

endmodule

// ----- hw/rtl/tkheap_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkheap_ctrl
// heap sequencer: push, pop, clear and drain with hole-based sift up / down
// ----------------------------------------------------------------------------
module tkheap_ctrl #(
    parameter int MAX_ENTRIES = tkheap_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = tkheap_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS  = tkheap_pkg::DEF_VALUE_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request side
    input  logic                             in_valid,
    output logic                             in_ready,
    input  tkheap_pkg::op_t                  in_op,
    input  logic [KEY_BITS-1:0]              in_key,
    input  logic [VALUE_BITS-1:0]            in_value,
    input  logic [tkheap_pkg::CFG_BITS-1:0]  k_eff,
    // result side
    output logic                             res_valid,
    input  logic                             res_ready,
    output tkheap_pkg::res_tag_t             res_tag,
    output logic [KEY_BITS-1:0]              res_key,
    output logic [VALUE_BITS-1:0]            res_value,
    // memory side
    output logic                             mem_wr_en,
    output logic [$clog2(MAX_ENTRIES)-1:0]   mem_wr_addr,
    output logic [KEY_BITS+VALUE_BITS-1:0]   mem_wr_data,
    output logic                             mem_rd_en,
    output logic [$clog2(MAX_ENTRIES)-1:0]   mem_rd_addr_a,
    output logic [$clog2(MAX_ENTRIES)-1:0]   mem_rd_addr_b,
    input  logic [KEY_BITS+VALUE_BITS-1:0]   mem_rd_data_a,
    input  logic [KEY_BITS+VALUE_BITS-1:0]   mem_rd_data_b
);
    import tkheap_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = AW + 2;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    status_t               stat_reg, stat_next;
    logic [KEY_BITS-1:0]   mov_key_reg, mov_key_next;
    logic [VALUE_BITS-1:0] mov_val_reg, mov_val_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         count_reg, count_next;

    logic [KEY_BITS-1:0]   rd_a_key, rd_b_key, ch_key;
    logic [VALUE_BITS-1:0] rd_a_val, rd_b_val, ch_val;
    logic [XW-1:0]         child1, child2, ch_idx;
    logic [AW-1:0]         parent;
    logic [CW-1:0]         cnt_m1;
    logic [COUNT_BITS-1:0] cnt_ext, cnt_m1_ext;
    logic                  leaf, child2_ok, pick_b, dn_move, up_move, replace, push_room;
    state_t                after_sift;

    assign rd_a_key = mem_rd_data_a[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
    assign rd_a_val = mem_rd_data_a[VALUE_BITS-1:0];
    assign rd_b_key = mem_rd_data_b[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
    assign rd_b_val = mem_rd_data_b[VALUE_BITS-1:0];

    assign child1     = XW'({pos_reg, 1'b1});
    assign child2     = child1 + XW'(1);
    assign parent     = (pos_reg - AW'(1)) >> 1;
    assign cnt_m1     = count_reg - CW'(1);
    assign cnt_ext    = COUNT_BITS'(count_reg);
    assign cnt_m1_ext = COUNT_BITS'(cnt_m1);

    assign leaf      = child1 >= XW'(count_reg);
    assign child2_ok = child2 < XW'(count_reg);
    assign pick_b    = child2_ok && ($signed(rd_b_val) < $signed(rd_a_val));
    assign ch_key    = pick_b ? rd_b_key : rd_a_key;
    assign ch_val    = pick_b ? rd_b_val : rd_a_val;
    assign ch_idx    = pick_b ? child2 : child1;
    assign dn_move   = $signed(ch_val) < $signed(mov_val_reg);
    assign up_move   = $signed(mov_val_reg) < $signed(rd_a_val);
    assign replace   = $signed(rd_a_val) < $signed(mov_val_reg);
    assign push_room = cnt_ext < k_eff;

    // where a finished sift down goes on
    always_comb begin
        if (op_reg == OP_PUSH) begin
            after_sift = ST_PUSH_RES;
        end else if (op_reg == OP_DRAIN && count_reg != '0) begin
            after_sift = ST_POP_RD;
        end else begin
            after_sift = ST_IDLE;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    case (in_op)
                        OP_PUSH:  state_next = push_room ? ST_UP_RD : ST_PUSH_CHK;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = (count_reg == '0) ? ST_EMPTY : ST_POP_RD;
                    endcase
                end
            end
            ST_PUSH_CHK: state_next = replace ? ST_DN_RD : ST_PUSH_RES;
            ST_UP_RD:    state_next = (pos_reg == '0) ? ST_PUSH_RES : ST_UP_CMP;
            ST_UP_CMP:   state_next = up_move ? ST_UP_RD : ST_PUSH_RES;
            ST_POP_RD:   state_next = ST_POP_EMIT;
            ST_POP_EMIT: begin
                if (res_ready) begin
                    state_next = ST_DN_RD;
                end
            end
            ST_DN_RD:    state_next = leaf ? after_sift : ST_DN_CMP;
            ST_DN_CMP:   state_next = dn_move ? ST_DN_RD : after_sift;
            ST_PUSH_RES, ST_CLEAR, ST_EMPTY: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath, memory access and results
    always_comb begin
        op_next       = op_reg;
        stat_next     = stat_reg;
        mov_key_next  = mov_key_reg;
        mov_val_next  = mov_val_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        in_ready      = 1'b0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = pos_reg;
        mem_wr_data   = {mov_key_reg, mov_val_reg};
        mem_rd_en     = 1'b0;
        mem_rd_addr_a = '0;
        mem_rd_addr_b = '0;
        res_valid     = 1'b0;
        res_tag       = '{status: STAT_OK, count_after: cnt_ext, last: 1'b1};
        res_key       = '0;
        res_value     = '0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next      = in_op;
                    stat_next    = STAT_OK;
                    mov_key_next = in_key;
                    mov_val_next = in_value;
                    if (in_op == OP_PUSH && push_room) begin
                        pos_next   = AW'(count_reg);
                        count_next = count_reg + CW'(1);
                    end
                    // full heap: fetch the root for the replace test
                    if (in_op == OP_PUSH && !push_room) begin
                        mem_rd_en = 1'b1;
                        pos_next  = '0;
                    end
                    if (in_op == OP_CLEAR) begin
                        count_next = '0;
                    end
                end
            end
            ST_PUSH_CHK: begin
                if (!replace) begin
                    stat_next = STAT_REJECT;
                end
            end
            ST_UP_RD: begin
                if (pos_reg == '0) begin
                    mem_wr_en = 1'b1;
                end else begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr_a = parent;
                end
            end
            ST_UP_CMP: begin
                mem_wr_en = 1'b1;
                if (up_move) begin
                    mem_wr_data = mem_rd_data_a;
                    pos_next    = parent;
                end
            end
            ST_POP_RD: begin
                mem_rd_en     = 1'b1;
                mem_rd_addr_b = cnt_m1[AW-1:0];
            end
            ST_POP_EMIT: begin
                res_valid = 1'b1;
                res_tag   = '{status: STAT_OK, count_after: cnt_m1_ext,
                              last: (op_reg == OP_POP) || (cnt_m1 == '0)};
                res_key   = rd_a_key;
                res_value = rd_a_val;
                if (res_ready) begin
                    mov_key_next = rd_b_key;
                    mov_val_next = rd_b_val;
                    count_next   = cnt_m1;
                    pos_next     = '0;
                end
            end
            ST_DN_RD: begin
                if (leaf) begin
                    mem_wr_en = 1'b1;
                end else begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr_a = child1[AW-1:0];
                    mem_rd_addr_b = child2[AW-1:0];
                end
            end
            ST_DN_CMP: begin
                mem_wr_en = 1'b1;
                if (dn_move) begin
                    mem_wr_data = {ch_key, ch_val};
                    pos_next    = ch_idx[AW-1:0];
                end
            end
            ST_PUSH_RES: begin
                res_valid = 1'b1;
                res_tag   = '{status: stat_reg, count_after: cnt_ext, last: 1'b1};
            end
            ST_CLEAR: begin
                res_valid = 1'b1;
            end
            ST_EMPTY: begin
                res_valid = 1'b1;
                res_tag   = '{status: STAT_EMPTY, count_after: cnt_ext, last: 1'b1};
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        stat_reg    <= stat_next;
        mov_key_reg <= mov_key_next;
        mov_val_reg <= mov_val_next;
        pos_reg     <= pos_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_wr_en && mem_rd_en))
        else $error("memory read and write in the same cycle");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && in_valid && in_op == OP_PUSH && push_room)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the heap");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP_EMIT) |-> (count_reg != '0))
        else $error("pop from an empty heap");

    a_sift_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DN_CMP || state_reg == ST_UP_CMP)
        |-> (XW'(pos_reg) < XW'(count_reg)))
        else $error("sift position outside the heap");
`endif

endmodule

// ----- hw/rtl/top_k_min_heap_selector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_min_heap_selector
// keeps the k largest (key, value) pairs in a binary min-heap held in memory
// ----------------------------------------------------------------------------
// sequencing: a push sifts up, a replacing push sifts down from the root, a pop
//   or drained entry is emitted, then sifted down; no new request is taken till
//   the sift ends, as the single heap memory is walked one level at a time
// reset: sequencer idle, heap empty, k_retained back to 64; heap memory
//   contents are left as they are and never read before being written
// ----------------------------------------------------------------------------
module top_k_min_heap_selector #(
    parameter int MAX_ENTRIES = tkheap_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = tkheap_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS  = tkheap_pkg::DEF_VALUE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration: k_retained
    input  logic                                cfg_we,
    input  logic [tkheap_pkg::CFG_BITS-1:0]     cfg_wdata,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // item_key, item_value
    input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
    // operation
    input  logic [tkheap_pkg::OP_BITS-1:0]      s_tuser,
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status, out_key, out_value, count_after
    output logic [((tkheap_pkg::STATUS_BITS+KEY_BITS+VALUE_BITS
                    +tkheap_pkg::COUNT_BITS+7)/8)*8-1:0] m_tdata,
    output logic                                m_tlast
);
    import tkheap_pkg::*;

    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int EW    = KEY_BITS + VALUE_BITS;
    localparam int OUT_W = ((STATUS_BITS + KEY_BITS + VALUE_BITS + COUNT_BITS + 7) / 8) * 8;

    // k_retained register and its clamp to 1..MAX_ENTRIES
    logic [CFG_BITS-1:0] k_reg;
    logic [CFG_BITS-1:0] k_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= K_RESET;
        end else if (cfg_we) begin
            k_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (k_reg == '0) begin
            k_eff = CFG_BITS'(1);
        end else if (k_reg > CFG_BITS'(MAX_ENTRIES)) begin
            k_eff = CFG_BITS'(MAX_ENTRIES);
        end else begin
            k_eff = k_reg;
        end
    end

    // memory hookup
    logic          mem_wr_en, mem_rd_en;
    logic [AW-1:0] mem_wr_addr, mem_rd_addr_a, mem_rd_addr_b;
    logic [EW-1:0] mem_wr_data, mem_rd_data_a, mem_rd_data_b;

    // result from the sequencer
    logic                  res_valid, res_ready;
    res_tag_t              res_tag;
    logic [KEY_BITS-1:0]   res_key;
    logic [VALUE_BITS-1:0] res_value;

    tkheap_mem #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ENTRY_BITS  (EW)
    ) u_mem (
        .aclk      (aclk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_en     (mem_rd_en),
        .rd_addr_a (mem_rd_addr_a),
        .rd_addr_b (mem_rd_addr_b),
        .rd_data_a (mem_rd_data_a),
        .rd_data_b (mem_rd_data_b)
    );

    tkheap_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_op         (op_t'(s_tuser)),
        .in_key        (s_tdata[KEY_BITS-1:0]),
        .in_value      (s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS]),
        .k_eff         (k_eff),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_tag       (res_tag),
        .res_key       (res_key),
        .res_value     (res_value),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr_a (mem_rd_addr_a),
        .mem_rd_addr_b (mem_rd_addr_b),
        .mem_rd_data_a (mem_rd_data_a),
        .mem_rd_data_b (mem_rd_data_b)
    );

    // output register: a waiting result does not hold up the next request
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic             m_tlast_reg, m_tlast_next;

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            // packed low to high: status, key, value, count
            m_tdata_next  = OUT_W'({res_tag.count_after, res_value, res_key, res_tag.status});
            m_tlast_next  = res_tag.last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the top-k min-heap selector against a behavioral heap model:
// directed corner cases, then random push/pop/clear/drain traffic over
// several k settings, with random valid and ready bursts on both channels
// ----------------------------------------------------------------------------
module testbench;
    import tkheap_pkg::*;

    localparam int  MAX_ENTRIES  = 64;
    localparam int  KEY_BITS     = 24;
    localparam int  VALUE_BITS   = 32;
    localparam int  S_DATA_BITS  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int  M_DATA_BITS  = ((STATUS_BITS + KEY_BITS + VALUE_BITS + COUNT_BITS + 7) / 8) * 8;
    localparam int  LIMIT_CYCLES = 2000000;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  REPORT_MAX   = 10;
    localparam int  NUM_PHASES   = 8;

    // one request on the input channel
    typedef struct {
        op_t                          op;
        logic [KEY_BITS-1:0]          key;
        logic signed [VALUE_BITS-1:0] value;
    } heap_req_t;

    // one result on the output channel
    typedef struct {
        status_t                      status;
        logic [KEY_BITS-1:0]          key;
        logic [VALUE_BITS-1:0]        value;
        logic [COUNT_BITS-1:0]        count;
        logic                         last;
    } heap_result_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_BITS-1:0]     cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_DATA_BITS-1:0]  s_tdata   = '0;   // item_key, item_value
    logic [OP_BITS-1:0]      s_tuser   = '0;   // operation
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_DATA_BITS-1:0]  m_tdata;          // status, out_key, out_value, count_after
    logic                    m_tlast;

    top_k_min_heap_selector #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 12 ns clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // heap model: own copy of the heap, its count and the k setting
    // ------------------------------------------------------------------------
    logic [KEY_BITS-1:0]          model_keys [MAX_ENTRIES];
    logic signed [VALUE_BITS-1:0] model_vals [MAX_ENTRIES];
    int unsigned                  model_count = 0;
    int unsigned                  model_k     = K_RESET;

    heap_req_t    request_backlog[$];    // requests not yet offered to the block
    heap_result_t heap_results_due[$];   // results the block still owes, oldest first

    int  fail_count     = 0;
    int  cycle_count    = 0;
    bit  calm_tail      = 1'b0;   // no idling on either side in the closing phase
    bit  s_fire         = 1'b0;   // a request was taken at the last rising edge
    int  send_gap       = 0;
    int  stall_left     = 0;
    heap_req_t drive_req;

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [KEY_BITS-1:0]          tk;
        logic signed [VALUE_BITS-1:0] tv;
        tk = model_keys[a];
        model_keys[a] = model_keys[b];
        model_keys[b] = tk;
        tv = model_vals[a];
        model_vals[a] = model_vals[b];
        model_vals[b] = tv;
    endfunction

    function automatic void sift_toward_root(int unsigned pos);
        int unsigned parent;
        while (pos > 0) begin
            parent = (pos - 1) >> 1;
            if (!(model_vals[pos] < model_vals[parent]))
                break;
            swap_slots(pos, parent);
            pos = parent;
        end
    endfunction

    function automatic void sift_from_root(int unsigned n);
        int unsigned p;
        int unsigned c;
        p = 0;
        forever begin
            c = 2 * p + 1;
            if (c >= n)
                return;
            // pick the smaller child, left wins a tie
            if (c + 1 < n && model_vals[c + 1] < model_vals[c])
                c++;
            if (!(model_vals[c] < model_vals[p]))
                return;
            swap_slots(p, c);
            p = c;
        end
    endfunction

    function automatic void take_minimum(output logic [KEY_BITS-1:0] k,
                                         output logic signed [VALUE_BITS-1:0] v);
        k = model_keys[0];
        v = model_vals[0];
        model_count--;
        model_keys[0] = model_keys[model_count];
        model_vals[0] = model_vals[model_count];
        sift_from_root(model_count);
    endfunction

    // advance the heap model by one request and queue the results it causes
    function automatic void apply_heap_request(heap_req_t req);
        int unsigned                  k_eff;
        heap_result_t                 res;
        logic [KEY_BITS-1:0]          rk;
        logic signed [VALUE_BITS-1:0] rv;
        k_eff = (model_k == 0) ? 1 : ((model_k > MAX_ENTRIES) ? MAX_ENTRIES : model_k);
        res.status = STAT_OK;
        res.key    = '0;
        res.value  = '0;
        res.last   = 1'b1;
        case (req.op)
            OP_PUSH: begin
                if (model_count < k_eff) begin
                    model_keys[model_count] = req.key;
                    model_vals[model_count] = req.value;
                    model_count++;
                    sift_toward_root(model_count - 1);
                end else if (model_count > 0 && model_vals[0] < req.value) begin
                    // full heap: strictly larger value replaces the root
                    model_keys[0] = req.key;
                    model_vals[0] = req.value;
                    sift_from_root(model_count);
                end else begin
                    res.status = STAT_REJECT;
                end
                res.count = model_count[COUNT_BITS-1:0];
                heap_results_due.push_back(res);
            end
            OP_CLEAR: begin
                model_count = 0;
                res.count = '0;
                heap_results_due.push_back(res);
            end
            default: begin
                if (model_count == 0) begin
                    res.status = STAT_EMPTY;
                    res.count  = '0;
                    heap_results_due.push_back(res);
                end else if (req.op == OP_POP) begin
                    take_minimum(rk, rv);
                    res.key   = rk;
                    res.value = rv;
                    res.count = model_count[COUNT_BITS-1:0];
                    heap_results_due.push_back(res);
                end else begin
                    // drain: ascending order, last flag on the final entry
                    while (model_count > 0) begin
                        take_minimum(rk, rv);
                        res.key   = rk;
                        res.value = rv;
                        res.count = model_count[COUNT_BITS-1:0];
                        res.last  = (model_count == 0);
                        heap_results_due.push_back(res);
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // request driver: changes inputs at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (request_backlog.size() > 0) begin
                drive_req = request_backlog.pop_front();
                s_tvalid  <= 1'b1;
                s_tuser   <= drive_req.op;
                s_tdata   <= {drive_req.value, drive_req.key};
                // random idle burst ahead of the next request
                if (!calm_tail && $urandom_range(0, 4) == 0)
                    send_gap <= $urandom_range(1, 9);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result-side ready with random stall bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!calm_tail && $urandom_range(0, 6) == 0)
                stall_left <= $urandom_range(1, 9);
        end
    end

    // ------------------------------------------------------------------------
    // request capture: model runs on every accepted request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        heap_req_t taken;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            taken.op    = op_t'(s_tuser);
            taken.key   = s_tdata[KEY_BITS-1:0];
            taken.value = s_tdata[KEY_BITS +: VALUE_BITS];
            apply_heap_request(taken);
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: each accepted result against the oldest one owed
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        heap_result_t want;
        heap_result_t got;
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, heap_results_due.size());
            $display("testbench: errors");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            got.status = status_t'(m_tdata[STATUS_BITS-1:0]);
            got.key    = m_tdata[STATUS_BITS +: KEY_BITS];
            got.value  = m_tdata[STATUS_BITS + KEY_BITS +: VALUE_BITS];
            got.count  = m_tdata[STATUS_BITS + KEY_BITS + VALUE_BITS +: COUNT_BITS];
            got.last   = m_tlast;
            if (heap_results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: status %0d key %h value %h count %0d last %b",
                             got.status, got.key, got.value, got.count, got.last);
            end else begin
                want = heap_results_due.pop_front();
                if (got.status !== want.status || got.key !== want.key ||
                    got.value !== want.value || got.count !== want.count ||
                    got.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  exp: status %0d key %h value %h count %0d last %b",
                                 want.status, want.key, want.value, want.count, want.last);
                        $display("  got: status %0d key %h value %h count %0d last %b",
                                 got.status, got.key, got.value, got.count, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic queue_request(op_t op, logic [KEY_BITS-1:0] key,
                                 logic signed [VALUE_BITS-1:0] value);
        heap_req_t r;
        r.op    = op;
        r.key   = key;
        r.value = value;
        request_backlog.push_back(r);
    endtask

    // block has taken every request, returned every result and finished its sift
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (request_backlog.size() != 0 || s_tvalid || heap_results_due.size() != 0 ||
               !s_tready);
    endtask

    // register write, only ever issued while idle
    task automatic write_k(int unsigned k);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= k[CFG_BITS-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
        model_k = k & 7'h7f;
    endtask

    int unsigned phase_k     [NUM_PHASES] = '{0, 64, 127, 3, 16, 1, 40, 64};
    int          phase_items [NUM_PHASES] = '{30, 55, 66, 40, 40, 30, 40, 35};
    int          phase_push  [NUM_PHASES] = '{65, 70, 88, 65, 75, 60, 72, 70};

    initial begin
        int      pick;
        op_t     op;
        logic signed [VALUE_BITS-1:0] v;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty heap cases, then field extremes at the reset k of 64
        queue_request(OP_POP,   24'h000000, 32'sd0);
        queue_request(OP_DRAIN, 24'h000000, 32'sd0);
        queue_request(OP_PUSH,  24'hffffff, 32'sh7fffffff);
        queue_request(OP_PUSH,  24'h000000, 32'sh80000000);
        queue_request(OP_PUSH,  24'h123456, 32'sd0);
        queue_request(OP_PUSH,  24'h654321, -32'sd1);
        queue_request(OP_PUSH,  24'h000005, 32'sd0);        // equal values below k
        queue_request(OP_POP,   24'h000000, 32'sd0);
        queue_request(OP_DRAIN, 24'h000000, 32'sd0);
        queue_request(OP_CLEAR, 24'h000000, 32'sd0);        // clear on empty
        queue_request(OP_PUSH,  24'haaaaaa, 32'sh55555555);
        queue_request(OP_PUSH,  24'h555555, 32'shaaaaaaaa);
        queue_request(OP_CLEAR, 24'h000000, 32'sd0);
        queue_request(OP_POP,   24'h000000, 32'sd0);
        wait_idle();

        // small k: full heap, equal value to root rejected, replace path
        write_k(2);
        @(posedge aclk);
        queue_request(OP_PUSH, 24'h000010, 32'sd10);
        queue_request(OP_PUSH, 24'h000020, 32'sd20);
        queue_request(OP_PUSH, 24'h000011, 32'sd10);
        queue_request(OP_PUSH, 24'h000005, 32'sd5);
        queue_request(OP_PUSH, 24'h000030, 32'sd30);
        queue_request(OP_POP,  24'h000000, 32'sd0);
        queue_request(OP_PUSH, 24'h000040, 32'sd40);
        wait_idle();

        // k lowered below the count: pushes go through the root
        write_k(1);
        @(posedge aclk);
        queue_request(OP_PUSH,  24'h000035, 32'sd35);
        queue_request(OP_PUSH,  24'h000021, 32'sd20);
        queue_request(OP_DRAIN, 24'h000000, 32'sd0);
        wait_idle();

        // random phases, including k of 0 and k above the heap size
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_k(phase_k[ph]);
            if (ph == NUM_PHASES - 1)
                calm_tail = 1'b1;
            @(posedge aclk);
            for (int i = 0; i < phase_items[ph]; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < phase_push[ph])
                    op = OP_PUSH;
                else if (pick < phase_push[ph] + (100 - phase_push[ph]) * 6 / 10)
                    op = OP_POP;
                else if (pick < 96)
                    op = OP_DRAIN;
                else
                    op = OP_CLEAR;
                // narrow values give ties, wide values toggle every bit
                case ($urandom_range(0, 3))
                    0:       v = $signed($urandom_range(0, 8)) - 32'sd4;
                    1:       v = ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
                    default: v = $urandom;
                endcase
                queue_request(op, KEY_BITS'($urandom), v);
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (heap_results_due.size() != 0) begin
            fail_count++;
            $display("%0d results never arrived", heap_results_due.size());
        end
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ----- top_k_min_heap_selector.f -----
hw/rtl/tkheap_pkg.sv
hw/rtl/tkheap_mem.sv
hw/rtl/tkheap_ctrl.sv
hw/rtl/top_k_min_heap_selector.sv
dv/testbench.sv
